// File: hdl/i2r_pkg.sv
package i2r_pkg;

    // Width of the two's-complement number that is converted. Bits of the
    // input above this width are ignored.
    localparam int NUMBER_WIDTH = 64;

    // Magnitude width. The most negative value saturates so it fits.
    localparam int MAG_W = NUMBER_WIDTH - 1;

    // One digit per magnitude bit covers the worst case of base 2.
    localparam int STORE_DEPTH = MAG_W;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    // Quotient bits resolved per divider cycle, and the padded dividend width.
    localparam int DIV_STEP   = 4;
    localparam int DIV_QW     = ((MAG_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int DIV_ITER   = DIV_QW / DIV_STEP;
    localparam int DIV_ITER_W = $clog2(DIV_ITER);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    typedef struct packed {
        logic                 start;
        logic [RADIX_W-1:0]   divisor;
        logic [MAG_W-1:0]     dividend;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIGIT_W-1:0]   remainder;
        logic [MAG_W-1:0]     quotient;
    } t_div_rsp;

    // Digit value to its ASCII glyph: 0-9 then a-z.
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DIGIT_W'(10)) begin
            ch = CHAR_W'(CHAR_ZERO + CHAR_W'(d));
        end else if (d < DIGIT_W'(36)) begin
            ch = CHAR_W'(CHAR_LOW_A + CHAR_W'(d) - CHAR_W'(10));
        end else begin
            ch = CHAR_ZERO;
        end
        return ch;
    endfunction

endpackage

// File: hdl/i2r_ram.sv
module i2r_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/i2r_div.sv
// Restoring divider of the magnitude by a small radix. Several quotient bits
// are resolved per cycle; the result is flagged by a one-cycle done pulse.
module i2r_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  i2r_pkg::t_div_req i_req,
    output i2r_pkg::t_div_rsp o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic [i2r_pkg::DIV_ITER_W-1:0]     r_cnt;
    logic [i2r_pkg::DIV_QW-1:0]         r_q;
    logic [i2r_pkg::DIGIT_W-1:0]        r_rem;
    logic [i2r_pkg::RADIX_W-1:0]        r_div;

    logic [i2r_pkg::DIV_QW-1:0]         n_q;
    logic [i2r_pkg::DIGIT_W-1:0]        n_rem;

    always_comb begin
        logic [i2r_pkg::DIGIT_W:0] t;
        n_q   = r_q;
        n_rem = r_rem;
        for (int k = 0; k < i2r_pkg::DIV_STEP; k++) begin
            t   = {n_rem, n_q[i2r_pkg::DIV_QW-1]};
            n_q = {n_q[i2r_pkg::DIV_QW-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                n_rem  = i2r_pkg::DIGIT_W'(t - {1'b0, r_div});
                n_q[0] = 1'b1;
            end else begin
                n_rem = t[i2r_pkg::DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_q    <= i2r_pkg::DIV_QW'(i_req.dividend);
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            if (r_cnt == i2r_pkg::DIV_ITER_W'(i2r_pkg::DIV_ITER - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;
    assign o_rsp.quotient  = r_q[i2r_pkg::MAG_W-1:0];

endmodule

// File: hdl/integer_to_radix_digits_unit.sv
// Converts one signed integer to its ASCII text in a radix from 2 to 36 and
// sends it out one character per output transfer, most significant first.
// A negative value is preceded by '-', digits are 0-9 then a-z, zero gives
// a single '0', and the final character carries o_last. A radix outside
// 2..36 gives a single transfer with o_char_code 0, o_last and o_bad_radix
// set. Only the low NUMBER_WIDTH bits of i_number are used; the most negative
// value is converted as one more than itself. The block takes one number at
// a time: o_ready is high only while it is idle. Digits are found by a single
// divider that resolves four quotient bits per cycle; the digits are buffered
// in a small RAM and then read back in reverse order, each character read in
// S_FETCH and sent in S_PUT, after the '-' of a negative value in S_SIGN.
module integer_to_radix_digits_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [63:0]                   i_number,
    input  logic [i2r_pkg::RADIX_W-1:0]   i_radix,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [i2r_pkg::CHAR_W-1:0]    o_char_code,
    output logic                          o_last,
    output logic                          o_bad_radix
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_FETCH,
        S_PUT,
        S_ERR
    } t_state;

    t_state                              r_state;
    logic                                r_neg;
    logic [i2r_pkg::RADIX_W-1:0]         r_radix;
    logic [i2r_pkg::CNT_W-1:0]           r_count;
    logic [i2r_pkg::ADDR_W-1:0]          r_idx;
    logic                                r_o_valid;
    logic [i2r_pkg::CHAR_W-1:0]          r_o_char;
    logic                                r_o_last;
    logic                                r_o_bad;

    logic [i2r_pkg::NUMBER_WIDTH-1:0]    w_raw;
    logic [i2r_pkg::NUMBER_WIDTH-1:0]    w_negated;
    logic [i2r_pkg::NUMBER_WIDTH-1:0]    w_top;
    logic [i2r_pkg::MAG_W-1:0]           w_mag;
    logic                                w_radix_ok;
    logic                                w_in_xfer;
    logic                                w_out_free;
    logic                                w_out_load;
    logic [i2r_pkg::CNT_W-1:0]           w_cnt_nxt;
    logic                                w_more;
    logic [i2r_pkg::DIGIT_W-1:0]         w_rd_data;

    i2r_pkg::t_div_req                   w_div_req;
    i2r_pkg::t_div_rsp                   w_div_rsp;

    // Magnitude of the incoming number; the most negative value saturates.
    assign w_raw     = i_number[i2r_pkg::NUMBER_WIDTH-1:0];
    assign w_negated = -w_raw;
    assign w_top     = {1'b1, {(i2r_pkg::NUMBER_WIDTH - 1){1'b0}}};

    always_comb begin
        if (!w_raw[i2r_pkg::NUMBER_WIDTH-1]) begin
            w_mag = w_raw[i2r_pkg::MAG_W-1:0];
        end else if (w_raw == w_top) begin
            w_mag = '1;
        end else begin
            w_mag = w_negated[i2r_pkg::MAG_W-1:0];
        end
    end

    assign w_radix_ok = (i_radix >= i2r_pkg::RADIX_MIN) && (i_radix <= i2r_pkg::RADIX_MAX);
    assign o_ready    = (r_state == S_IDLE);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;

    // A new character enters the output register in this cycle.
    assign w_out_load = w_out_free
                        && ((r_state == S_SIGN) || (r_state == S_PUT) || (r_state == S_ERR));

    // Another digit is needed while the quotient is nonzero and the buffer
    // still has room.
    assign w_cnt_nxt = r_count + 1'b1;
    assign w_more    = (w_div_rsp.quotient != '0)
                       && (w_cnt_nxt < i2r_pkg::CNT_W'(i2r_pkg::STORE_DEPTH));

    // The first division starts on the input transfer; each further one
    // starts in the cycle the previous one finishes, from its quotient.
    always_comb begin
        if (r_state == S_IDLE) begin
            w_div_req.start    = w_in_xfer && w_radix_ok;
            w_div_req.divisor  = i_radix;
            w_div_req.dividend = w_mag;
        end else begin
            w_div_req.start    = (r_state == S_DIV) && w_div_rsp.done && w_more;
            w_div_req.divisor  = r_radix;
            w_div_req.dividend = w_div_rsp.quotient;
        end
    end

    i2r_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Digit buffer, filled least significant first and read back in reverse.
    i2r_ram #(
        .WIDTH (i2r_pkg::DIGIT_W),
        .DEPTH (i2r_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   ((r_state == S_DIV) && w_div_rsp.done),
        .i_wr_addr (r_count[i2r_pkg::ADDR_W-1:0]),
        .i_wr_data (w_div_rsp.remainder),
        .i_rd_en   (r_state == S_FETCH),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_neg     <= 1'b0;
            r_count   <= '0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_radix <= i_radix;
                        if (!w_radix_ok) begin
                            r_state <= S_ERR;
                        end else begin
                            r_neg   <= w_raw[i2r_pkg::NUMBER_WIDTH-1];
                            r_count <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_count <= w_cnt_nxt;
                        if (!w_more) begin
                            // The most significant digit sits at the slot
                            // just written.
                            r_idx   <= r_count[i2r_pkg::ADDR_W-1:0];
                            r_state <= r_neg ? S_SIGN : S_FETCH;
                        end
                    end
                end
                S_SIGN: begin
                    if (w_out_free) begin
                        r_o_char  <= i2r_pkg::CHAR_MINUS;
                        r_o_last  <= 1'b0;
                        r_o_bad   <= 1'b0;
                        r_state   <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    if (w_out_free) begin
                        r_o_char  <= i2r_pkg::digit_glyph(w_rd_data);
                        r_o_last  <= (r_idx == '0);
                        r_o_bad   <= 1'b0;
                        if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_ERR: begin
                    if (w_out_free) begin
                        r_o_char  <= i2r_pkg::CHAR_NONE;
                        r_o_last  <= 1'b1;
                        r_o_bad   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_char_code = r_o_char;
    assign o_last      = r_o_last;
    assign o_bad_radix = r_o_bad;

endmodule
